FILE: src/positional_insert_delete_array_assert.svh
// ----------------------------------------------------------------------------
// Positional insert/delete array assertion macros
// Concurrent checks that compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PIDA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// Next-cycle implication, disabled during reset.
`define PIDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define PIDA_ASSERT_NOW(label, clk, rst, ante, cons)
`define PIDA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/pida_pkg.sv
// ----------------------------------------------------------------------------
// Positional insert/delete array package
// Sizes, request and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package pida_pkg;

  // Number of cells in the array.
  localparam int Depth = 16;
  // Bits to address one cell.
  localparam int SlotW = $clog2(Depth);
  // Bits of the entry count, which can hold Depth itself.
  localparam int CountW = $clog2(Depth + 1);
  // Width of the position field.
  localparam int PosW = 5;
  // Width used when comparing position against the count.
  localparam int CmpW = ((CountW > PosW) ? CountW : PosW) + 1;
  // Width of one entry.
  localparam int DataW = 32;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_t;

  // Broadcast control for the row of cells.
  typedef struct packed {
    cell_op_t           op;
    logic [SlotW-1:0]   slot;
    logic [DataW-1:0]   value;
  } cell_ctl_t;

endpackage

FILE: src/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// Positional insert/delete array
// Ordered array of signed entries held in a row of cells, with clear,
// insert at position, delete at position and read at position.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                | Fields
//  ---------+--------------------------+-------------------------------
//  request  | in_valid / in_stall      | mode, position, value
//  result   | out_valid / out_stall    | status, data_out, count_out
//
// Every item is decoded, checked and applied to all cells in the cycle it
// is accepted, so one item is taken per clock unless the result side
// stalls; its result is in the output register in the cycle after. The
// row of cells shifts in parallel. Reset clears the count and the output
// valid; cell contents are left as they are. The request side stalls only
// while a result is held and the result side stalls.
// ----------------------------------------------------------------------------
`include "positional_insert_delete_array_assert.svh"

module positional_insert_delete_array (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [pida_pkg::PosW-1:0]     position,
  input  logic signed [31:0]            value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic signed [31:0]            data_out,
  output logic [pida_pkg::CountW-1:0]   count_out
);

  logic [pida_pkg::CountW-1:0]  count;
  logic [pida_pkg::CountW-1:0]  count_next;
  logic                         in_acc;
  logic [pida_pkg::CmpW-1:0]    pos_ext;
  logic [pida_pkg::CmpW-1:0]    cnt_ext;
  logic [pida_pkg::PosW-1:0]    pos_m1;
  logic [pida_pkg::SlotW-1:0]   slot;
  pida_pkg::status_t            res_status;
  logic [pida_pkg::DataW-1:0]   res_data;
  pida_pkg::cell_ctl_t          ctl;
  pida_pkg::mode_t              req_mode;
  logic [pida_pkg::DataW-1:0]   cell_data [pida_pkg::Depth];

  // Handshake: a new item is taken unless a result is stuck at the output.
  assign in_stall = out_valid & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  assign req_mode = pida_pkg::mode_t'(mode);
  assign pos_ext  = pida_pkg::CmpW'(position);
  assign cnt_ext  = pida_pkg::CmpW'(count);
  assign pos_m1   = position - pida_pkg::PosW'(1);
  assign slot     = pos_m1[pida_pkg::SlotW-1:0];

  // Decode the request, check it and form the cell control and the result.
  always_comb begin
    res_status = pida_pkg::STAT_DONE;
    res_data   = '0;
    count_next = count;
    ctl.op     = pida_pkg::OP_HOLD;
    ctl.slot   = slot;
    ctl.value  = value;
    unique case (req_mode)
      pida_pkg::MODE_CLEAR: begin
        count_next = '0;
      end
      pida_pkg::MODE_INSERT: begin
        if (count == pida_pkg::CountW'(pida_pkg::Depth)) begin
          res_status = pida_pkg::STAT_FULL;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + pida_pkg::CmpW'(1)) begin
          res_status = pida_pkg::STAT_RANGE;
        end else begin
          ctl.op     = pida_pkg::OP_INSERT;
          count_next = count + pida_pkg::CountW'(1);
        end
      end
      default: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          res_status = pida_pkg::STAT_RANGE;
        end else begin
          res_data = cell_data[slot];
          if (req_mode == pida_pkg::MODE_DELETE) begin
            ctl.op     = pida_pkg::OP_DELETE;
            count_next = count - pida_pkg::CountW'(1);
          end
        end
      end
    endcase
    if (!in_acc) begin
      ctl.op     = pida_pkg::OP_HOLD;
      count_next = count;
    end
  end

  // Row of cells; each one sees its neighbors on both sides.
  for (genvar i = 0; i < pida_pkg::Depth; i++) begin : g_cell
    logic [pida_pkg::DataW-1:0] left_d;
    logic [pida_pkg::DataW-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = cell_data[i];
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == pida_pkg::Depth - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    pida_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (pida_pkg::SlotW'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i])
    );
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register, loaded with each accepted item.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status    <= res_status;
      data_out  <= res_data;
      count_out <= count_next;
    end
  end

  // Checks on the block's own logic.
  `PIDA_ASSERT_NOW(a_count_max, clk, rst, 1'b1, count <= pida_pkg::CountW'(pida_pkg::Depth))
  `PIDA_ASSERT_NOW(a_stall_needs_result, clk, rst, in_stall, out_valid)
  `PIDA_ASSERT_NEXT(a_insert_grows, clk, rst, in_acc && req_mode == pida_pkg::MODE_INSERT && res_status == pida_pkg::STAT_DONE, count == $past(count) + pida_pkg::CountW'(1))
  `PIDA_ASSERT_NOW(a_full_at_depth, clk, rst, out_valid && status == pida_pkg::STAT_FULL, count_out == pida_pkg::CountW'(pida_pkg::Depth))

endmodule

FILE: src/pida_cell.sv
// ----------------------------------------------------------------------------
// Positional insert/delete array cell
// Holds one entry and, on an insert or delete, takes its left neighbor,
// its right neighbor or the new value.
// ----------------------------------------------------------------------------
module pida_cell (
  input  logic                          clk,
  input  pida_pkg::cell_ctl_t           ctl,
  input  logic [pida_pkg::SlotW-1:0]    idx,
  input  logic [pida_pkg::DataW-1:0]    left_data,
  input  logic [pida_pkg::DataW-1:0]    right_data,
  output logic [pida_pkg::DataW-1:0]    data
);

  logic [pida_pkg::DataW-1:0] data_next;

  // Pick the next content of this cell.
  always_comb begin
    data_next = data;
    unique case (ctl.op)
      pida_pkg::OP_INSERT: begin
        if (idx > ctl.slot) begin
          data_next = left_data;
        end else if (idx == ctl.slot) begin
          data_next = ctl.value;
        end
      end
      pida_pkg::OP_DELETE: begin
        if (idx >= ctl.slot) begin
          data_next = right_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  // Entry storage; it needs no reset since only entries below the count are read.
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

FILE: tb/tb_positional_insert_delete_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional insert/delete array testbench
// Sends directed and random clear, insert, delete and read items with random
// gaps and output stalls, predicts every result with a local image of the
// array, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module tb_positional_insert_delete_array;
  import pida_pkg::*;

  typedef struct {
    mode_t             op;
    logic [PosW-1:0]   position;
    logic signed [31:0] value;
  } array_request_t;

  typedef struct {
    status_t             status;
    logic signed [31:0]  data;
    logic [CountW-1:0]   count;
  } array_reply_t;

  localparam int IdleLimit = 2000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 mode = MODE_CLEAR;
  logic [PosW-1:0]            position = '0;
  logic signed [31:0]         value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 status;
  logic signed [31:0]         data_out;
  logic [CountW-1:0]          count_out;

  // Items still to be sent, and replies owed by the block in order.
  array_request_t queued_requests[$];
  array_reply_t   owed_replies[$];

  // Local image of the array and its fill level.
  logic signed [31:0] cell_image[Depth];
  int                 image_count = 0;

  // Fill level as seen by the stimulus generator, which runs ahead.
  int  gen_count = 0;
  int  total_items = 0;
  int  accepted_items = 0;
  int  failures = 0;

  array_request_t in_flight;
  int  gap_left = 0;
  bit  calm_in = 1'b0;
  int  stall_left = 0;
  bit  calm_out = 1'b0;
  int  idle_cycles = 0;

  positional_insert_delete_array u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data_out  (data_out),
    .count_out (count_out)
  );

  always #6 clk = ~clk;

  // Applies one request to the array image and returns the reply it owes.
  function automatic array_reply_t apply_to_image(array_request_t req);
    array_reply_t reply;
    int slot;
    reply.status = STAT_DONE;
    reply.data = '0;
    slot = int'(req.position) - 1;
    case (req.op)
      MODE_CLEAR: begin
        image_count = 0;
      end
      MODE_INSERT: begin
        if (image_count >= Depth) begin
          reply.status = STAT_FULL;
        end else if (req.position == 0 || int'(req.position) > image_count + 1) begin
          reply.status = STAT_RANGE;
        end else begin
          for (int k = image_count; k > slot; k--) cell_image[k] = cell_image[k - 1];
          cell_image[slot] = req.value;
          image_count++;
        end
      end
      default: begin
        if (req.position == 0 || int'(req.position) > image_count) begin
          reply.status = STAT_RANGE;
        end else begin
          reply.data = cell_image[slot];
          if (req.op == MODE_DELETE) begin
            for (int k = slot; k + 1 < image_count; k++) cell_image[k] = cell_image[k + 1];
            image_count--;
          end
        end
      end
    endcase
    reply.count = image_count[CountW-1:0];
    return reply;
  endfunction

  // Queues one item and tracks the fill level it leaves behind.
  task automatic push_request(mode_t op, int pos, logic signed [31:0] val);
    array_request_t req;
    req.op = op;
    req.position = pos[PosW-1:0];
    req.value = val;
    queued_requests.push_back(req);
    total_items++;
    case (op)
      MODE_CLEAR: gen_count = 0;
      MODE_INSERT: begin
        if (gen_count < Depth && req.position != 0 && int'(req.position) <= gen_count + 1)
          gen_count++;
      end
      MODE_DELETE: begin
        if (req.position != 0 && int'(req.position) <= gen_count) gen_count--;
      end
      default: ;
    endcase
  endtask

  // Request driver: random gaps between items, with calm stretches of none.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = $urandom_range(9);
    end else begin
      if (in_valid && !in_stall) begin
        owed_replies.push_back(apply_to_image(in_flight));
        accepted_items++;
        if ($urandom_range(39) == 0) calm_in = !calm_in;
        gap_left = calm_in ? 0 : $urandom_range(9);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          in_flight = queued_requests.pop_front();
          in_valid <= 1'b1;
          mode <= in_flight.op;
          position <= in_flight.position;
          value <= in_flight.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each reply and stalls for a random while after it.
  always @(posedge clk) begin
    array_reply_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_replies.size() == 0) begin
          if (failures < 10)
            $display("%0t: result with nothing owed: status=%0d data=%0d count=%0d",
                     $realtime, status, data_out, count_out);
          failures++;
        end else begin
          want = owed_replies.pop_front();
          if (status !== want.status || data_out !== want.data ||
              count_out !== want.count) begin
            if (failures < 10)
              $display("%0t: expected status=%0d data=%0d count=%0d, got %0d %0d %0d",
                       $realtime, want.status, want.data, want.count,
                       status, data_out, count_out);
            failures++;
          end
        end
        if ($urandom_range(39) == 0) calm_out = !calm_out;
        stall_left = calm_out ? 0 : $urandom_range(9);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int seg_len;
    int seg_kind;
    int pick;
    int top;
    int pos;
    mode_t op;
    logic signed [31:0] val;

    // Directed part: empty array, bad positions, extreme values, full array.
    push_request(MODE_READ, 1, 32'sd5);
    push_request(MODE_DELETE, 1, 32'sd0);
    push_request(MODE_INSERT, 0, 32'sd7);
    push_request(MODE_INSERT, 31, 32'sd7);
    push_request(MODE_INSERT, 1, 32'sh7fffffff);
    push_request(MODE_INSERT, 1, 32'sh80000000);
    push_request(MODE_INSERT, 3, 32'sd0);
    push_request(MODE_DELETE, 2, -32'sd1);
    push_request(MODE_READ, 0, 32'sd0);
    while (gen_count < Depth)
      push_request(MODE_INSERT, $urandom_range(gen_count + 1, 1), $urandom());
    push_request(MODE_INSERT, 0, -32'sd1);
    push_request(MODE_READ, Depth, 32'sd0);
    push_request(MODE_DELETE, Depth, 32'sd0);
    push_request(MODE_CLEAR, 3, 32'sh7fffffff);
    push_request(MODE_READ, 1, 32'sd0);

    // Random part in segments that lean toward filling, draining or neither.
    while (total_items < 1380) begin
      seg_len = $urandom_range(80, 20);
      seg_kind = $urandom_range(2);
      repeat (seg_len) begin
        pick = $urandom_range(99);
        if (pick < 2) op = MODE_CLEAR;
        else if (seg_kind == 0) op = (pick < 72) ? MODE_INSERT : (pick < 87) ? MODE_DELETE : MODE_READ;
        else if (seg_kind == 1) op = (pick < 17) ? MODE_INSERT : (pick < 82) ? MODE_DELETE : MODE_READ;
        else op = (pick < 32) ? MODE_INSERT : (pick < 62) ? MODE_DELETE : MODE_READ;
        // Mostly legal positions; the rest anywhere in the field.
        top = (op == MODE_INSERT) ? gen_count + 1 : gen_count;
        if (top == 0 || $urandom_range(99) < 15) pos = $urandom_range(31);
        else pos = $urandom_range(top, 1);
        case ($urandom_range(39))
          0: val = 32'sh7fffffff;
          1: val = 32'sh80000000;
          2: val = 32'sd0;
          3: val = -32'sd1;
          default: val = $urandom();
        endcase
        push_request(op, pos, val);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Drain: every item taken and every reply seen, then a few quiet cycles.
    while (accepted_items != total_items || owed_replies.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    failures += owed_replies.size();
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
